FILE: rtl/bitmap_font_glyph_expander_macros.svh
// Assertion macros shared by the glyph expander checker.
// Included by bare file name; holds nothing but macro definitions.
`ifndef BITMAP_FONT_GLYPH_EXPANDER_MACROS_SVH
`define BITMAP_FONT_GLYPH_EXPANDER_MACROS_SVH

// Property checked on every rising edge outside reset.
`define BFGE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define BFGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bfge_pkg.sv
// Shared types and constants for the bitmap font glyph expander.
// No dependencies; used by the top level, the font store and the checker.
`default_nettype none

package bfge_pkg;

    // Default size of the font store in bytes.
    localparam int FONT_BYTES_DEF = 8192;

    // Glyph size limits; a row mask never exceeds 32 bits.
    localparam int MAX_GLYPH_W = 32;
    localparam int MAX_GLYPH_H = 32;
    localparam int LIM_W = (MAX_GLYPH_W < 32) ? MAX_GLYPH_W : 32;
    localparam int LIM_H = (MAX_GLYPH_H < 32) ? MAX_GLYPH_H : 32;

    // Font record layout.
    localparam int        FIRST_RECORD = 4;
    localparam int        HDR_BYTES    = 6;
    localparam logic [7:0] END_CODE    = 8'hFF;
    localparam logic [7:0] XOFF_NEG    = 8'h80;

    // Widest store address the parameter range allows.
    localparam int STORE_AW = 16;

    // Command codes carried in the input tuser bit.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Stream widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 96;

    // One access to the font store.
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_store_req;

endpackage

`default_nettype wire

FILE: rtl/bfge_store.sv
// Font store: single-port byte memory with a registered read.
// Depends on bfge_pkg for the access request type.
`default_nettype none

module bfge_store #(
    parameter int FONT_BYTES = bfge_pkg::FONT_BYTES_DEF
) (
    input  wire                    i_clk,
    input  wire bfge_pkg::t_store_req i_req,
    output logic [7:0]             o_rdata
);
    import bfge_pkg::*;

    localparam int AW = $clog2(FONT_BYTES);

    logic [7:0] r_mem [FONT_BYTES];
    logic [7:0] r_rdata;

    // One read per cycle at the requested address, plus a write there when we is set; a write cycle reads the old byte.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/bitmap_font_glyph_expander.sv
// Top level of the bitmap font glyph expander: sequencer, output register, pen color.
// Depends on bfge_pkg and bfge_store.
`default_nettype none

// A load beat writes one font byte. A draw beat walks the glyph records from byte 4
// through the single-port font store: each skipped record passes through a bound check,
// the reads of its six header bytes, a multiply for the bitmap size and a compare. A
// found glyph then shifts its bitmap out one pixel per cycle through a shared shifter,
// pausing to fetch each bitmap byte and to emit each row, and an emit waits while the
// output register is still full. The input is not ready during a draw; a finished row
// waits in an output register while the next row is built. The pen color may be
// written in any cycle and is taken when the block is idle.
module bitmap_font_glyph_expander #(
    parameter int FONT_BYTES = bfge_pkg::FONT_BYTES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // font_addr[12:0], font_byte[20:13], char_code[28:21], origin_x[44:29],
    // origin_y[60:45], zero pad[63:61]
    input  wire  [bfge_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  wire                              s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // row_x[15:0], row_y[31:16], row_mask[63:32], glyph_width[69:64],
    // advance[77:70], color[93:78], zero pad[95:94]
    output logic [bfge_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // found
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [15:0]                      i_cfg_data
);
    import bfge_pkg::*;

    localparam int AW   = $clog2(FONT_BYTES);
    localparam int SPAN = FONT_BYTES + 8192;
    localparam int PW   = $clog2(SPAN + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_HDR   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_LATCH = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // Input beat fields.
    logic        in_cmd;
    logic [12:0] in_addr;
    logic [7:0]  in_byte;
    logic [7:0]  in_char;
    logic [15:0] in_ox;
    logic [15:0] in_oy;
    assign in_cmd  = s_axis_tuser;
    assign in_addr = s_axis_tdata[12:0];
    assign in_byte = s_axis_tdata[20:13];
    assign in_char = s_axis_tdata[28:21];
    assign in_ox   = s_axis_tdata[44:29];
    assign in_oy   = s_axis_tdata[60:45];

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_k, n_k;
    logic [PW-1:0] r_rp, n_rp;
    logic [7:0]  r_hdr [HDR_BYTES];
    logic [7:0]  n_hdr [HDR_BYTES];
    logic [7:0]  r_char, n_char;
    logic [15:0] r_ox, n_ox;
    logic [15:0] r_oy, n_oy;
    logic [15:0] r_prod, n_prod;
    logic        r_found, n_found;
    logic        r_empty, n_empty;
    logic [15:0] r_rx, n_rx;
    logic [15:0] r_rowy, n_rowy;
    logic [7:0]  r_adv, n_adv;
    logic [AW-1:0] r_daddr, n_daddr;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_nbit, n_nbit;
    logic [4:0]  r_col, n_col;
    logic [4:0]  r_row, n_row;
    logic [31:0] r_mask, n_mask;
    logic        r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;
    logic        r_ouser, n_ouser;
    logic        r_olast, n_olast;
    logic [15:0] r_pen;

    t_store_req  store_req;
    logic [7:0]  store_rdata;

    // Header byte names.
    logic [7:0] h_code, h_yoff, h_w, h_h, h_xb, h_xadv;
    assign h_code = r_hdr[0];
    assign h_yoff = r_hdr[1];
    assign h_w    = r_hdr[2];
    assign h_h    = r_hdr[3];
    assign h_xb   = r_hdr[4];
    assign h_xadv = r_hdr[5];

    // Derived record quantities.
    logic [16:0]   prod_rnd;
    logic [13:0]   nbytes;
    logic [PW-1:0] rec_end;
    logic [PW-1:0] hdr_end;
    logic [15:0]   xoff_ext;
    logic          emit_last;
    logic          out_free;

    assign prod_rnd = {1'b0, r_prod} + 17'd7;
    assign nbytes   = prod_rnd[16:3];
    assign hdr_end  = r_rp + PW'(HDR_BYTES);
    assign rec_end  = hdr_end + PW'(nbytes);
    // Offset bytes of 0x80 and up stand for the byte value minus 255.
    assign xoff_ext = (h_xb >= XOFF_NEG) ? ({8'hFF, h_xb} + 16'd1) : {8'h00, h_xb};
    assign emit_last = !r_found || r_empty || ((6'(r_row) + 6'd1) == h_h[5:0]);
    assign out_free  = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);

    // Store access: load writes while idle, header reads, bitmap byte fetches.
    always_comb begin
        store_req.we    = 1'b0;
        store_req.wdata = in_byte;
        store_req.addr  = STORE_AW'(r_daddr);
        if (r_state == S_IDLE) begin
            store_req.addr = STORE_AW'(in_addr);
            store_req.we   = s_axis_tvalid && (in_cmd == CMD_LOAD)
                             && (32'(in_addr) < FONT_BYTES);
        end else if (r_state == S_HDR) begin
            store_req.addr = STORE_AW'(r_rp + PW'(r_k));
        end
    end

    bfge_store #(
        .FONT_BYTES(FONT_BYTES)
    ) u_bfge_store (
        .i_clk  (i_clk),
        .i_req  (store_req),
        .o_rdata(store_rdata)
    );

    // Sequencer next-state logic.
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_rp     = r_rp;
        n_hdr    = r_hdr;
        n_char   = r_char;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_prod   = r_prod;
        n_found  = r_found;
        n_empty  = r_empty;
        n_rx     = r_rx;
        n_rowy   = r_rowy;
        n_adv    = r_adv;
        n_daddr  = r_daddr;
        n_byte   = r_byte;
        n_nbit   = r_nbit;
        n_col    = r_col;
        n_row    = r_row;
        n_mask   = r_mask;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && (in_cmd == CMD_DRAW)) begin
                    n_char  = in_char;
                    n_ox    = in_ox;
                    n_oy    = in_oy;
                    n_rp    = PW'(FIRST_RECORD);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // A header that would run past the store ends the walk.
                n_k = 3'd0;
                if (hdr_end > PW'(FONT_BYTES)) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                // Read data comes back in the cycle after its address.
                if (r_k != 3'd0) begin
                    for (int i = 0; i < HDR_BYTES - 1; i++) begin
                        n_hdr[i] = r_hdr[i+1];
                    end
                    n_hdr[HDR_BYTES-1] = store_rdata;
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'(HDR_BYTES)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = 16'(h_w) * 16'(h_h);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (h_code == END_CODE) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end else if (h_code != r_char) begin
                    n_rp    = rec_end;
                    n_state = S_CHK;
                end else if ((h_w > 8'(LIM_W)) || (h_h > 8'(LIM_H))
                             || (rec_end > PW'(FONT_BYTES))) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_found = 1'b1;
                    n_empty = (h_w == 8'd0) || (h_h == 8'd0);
                    n_rx    = r_ox + xoff_ext;
                    n_rowy  = r_oy + {8'h00, h_yoff};
                    n_adv   = (h_w > h_xadv) ? h_w : h_xadv;
                    n_daddr = AW'(hdr_end);
                    n_nbit  = 4'd0;
                    n_col   = 5'd0;
                    n_row   = 5'd0;
                    n_mask  = 32'd0;
                    n_state = n_empty ? S_EMIT : S_FETCH;
                end
            end
            S_FETCH: begin
                n_daddr = r_daddr + AW'(1);
                n_state = S_LATCH;
            end
            S_LATCH: begin
                n_byte  = store_rdata;
                n_nbit  = 4'd8;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // Shared shifter: one pixel from the byte's top bit into the row mask.
                n_mask[r_col] = r_byte[7];
                n_byte = {r_byte[6:0], 1'b0};
                n_nbit = r_nbit - 4'd1;
                n_col  = r_col + 5'd1;
                if ((6'(r_col) + 6'd1) == h_w[5:0]) begin
                    n_state = S_EMIT;
                end else if (r_nbit == 4'd1) begin
                    n_state = S_FETCH;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_found;
                    n_olast  = emit_last;
                    if (r_found) begin
                        n_odata = {2'b00, r_pen, r_adv, h_w[5:0],
                                   (r_empty ? 32'd0 : r_mask), r_rowy, r_rx};
                    end else begin
                        n_odata = '0;
                    end
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 5'd1;
                        n_rowy  = r_rowy + 16'd1;
                        n_col   = 5'd0;
                        n_mask  = 32'd0;
                        n_state = (r_nbit == 4'd0) ? S_FETCH : S_SHIFT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pen    <= 16'hFFFF;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pen <= i_cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_rp    <= n_rp;
        r_hdr   <= n_hdr;
        r_char  <= n_char;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_prod  <= n_prod;
        r_found <= n_found;
        r_empty <= n_empty;
        r_rx    <= n_rx;
        r_rowy  <= n_rowy;
        r_adv   <= n_adv;
        r_daddr <= n_daddr;
        r_byte  <= n_byte;
        r_nbit  <= n_nbit;
        r_col   <= n_col;
        r_row   <= n_row;
        r_mask  <= n_mask;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

FILE: rtl/bfge_checker.sv
// Port-level checker for the bitmap font glyph expander, bound to the top level.
// Depends on bfge_pkg and bitmap_font_glyph_expander_macros.svh.
`default_nettype none

`include "bitmap_font_glyph_expander_macros.svh"

module bfge_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              s_axis_tuser,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [bfge_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire                              m_axis_tuser,
    input wire                              m_axis_tlast
);
    import bfge_pkg::*;

    // A stalled result beat keeps its payload.
    `BFGE_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

    // A miss is a single all-zero beat that closes the draw.
    `BFGE_ASSERT(a_miss_beat, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "miss beat is not a lone zero beat")

    // Accepting a draw beat closes the input while the walk runs.
    `BFGE_ASSERT(a_draw_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_DRAW) |=> !s_axis_tready, "input still ready after a draw beat")

    // A reported glyph row never exceeds the widest glyph.
    `BFGE_ASSERT(a_width_lim, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[69:64] <= 6'(LIM_W), "glyph width above limit")

    // Reset empties the output register.
    `BFGE_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result beat valid after reset")

endmodule

bind bitmap_font_glyph_expander bfge_checker u_bfge_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the bitmap font glyph expander.
// Loads fonts, draws characters and compares every row beat with a built-in predictor or a hand-written result.
// Depends on bfge_pkg and the bitmap_font_glyph_expander RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bfge_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int STORE_BYTES    = FONT_BYTES_DEF;
    localparam int DIR_ROWS       = 26;
    localparam int MIXED_ITEMS    = 24;
    localparam int DRAIN_PAUSE    = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    // One input beat, unpacked into its fields.
    typedef struct packed {
        logic        cmd;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [7:0]  ch;
        logic [15:0] ox;
        logic [15:0] oy;
    } font_cmd_t;

    // One output beat: found, position, mask, width, advance, color, last.
    typedef struct packed {
        logic        found;
        logic [15:0] row_x;
        logic [15:0] row_y;
        logic [31:0] mask;
        logic [5:0]  width;
        logic [7:0]  advance;
        logic [15:0] color;
        logic        last;
    } glyph_row_t;

    // A row of the directed stimulus, with a hand-written result where one is given.
    typedef struct packed {
        font_cmd_t  beat;
        logic       typed;
        glyph_row_t want;
    } dir_row_t;

    // A miss: every field zero except last, which is the lowest bit.
    localparam glyph_row_t MISS_ROW = glyph_row_t'(96'd1);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [15:0]            i_cfg_data;

    // Shadow of the font store and of the pen color.
    logic [7:0]  font_image [0:STORE_BYTES-1];
    bit          image_loaded [0:STORE_BYTES-1];
    logic [15:0] pen_color_now = 16'hFFFF;
    bit          hit_unloaded;

    glyph_row_t  glyph_rows[$];
    glyph_row_t  rows_due[$];
    logic [7:0]  font_codes[$];
    int unsigned bitmap_addrs[$];
    int unsigned font_end;

    dir_row_t    dir_plan [0:DIR_ROWS-1];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    bitmap_font_glyph_expander uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Read one shadow byte and note whether it was ever loaded.
    function automatic int unsigned font_peek(input int unsigned a);
        if (!image_loaded[a]) hit_unloaded = 1'b1;
        return font_image[a];
    endfunction

    // Walk the glyph records for one character and fill glyph_rows with the rows
    // the block should emit. Returns 0 if the walk touches a byte never loaded.
    function automatic bit render_glyph(input logic [7:0] ch, input logic [15:0] ox,
                                        input logic [15:0] oy);
        int unsigned ptr, code, yoff, w, h, xb, xadv, nbytes, adv, cursor, row, col;
        int unsigned bytev;
        logic [31:0] mask;
        glyph_row_t  r;
        glyph_rows.delete();
        hit_unloaded = 1'b0;
        ptr = FIRST_RECORD;
        while (1) begin
            if (ptr + HDR_BYTES > STORE_BYTES) begin
                glyph_rows.push_back(MISS_ROW);
                return !hit_unloaded;
            end
            code = font_peek(ptr);
            yoff = font_peek(ptr + 1);
            w    = font_peek(ptr + 2);
            h    = font_peek(ptr + 3);
            xb   = font_peek(ptr + 4);
            xadv = font_peek(ptr + 5);
            ptr += HDR_BYTES;
            if (code == END_CODE) begin
                glyph_rows.push_back(MISS_ROW);
                return !hit_unloaded;
            end
            nbytes = (w * h + 7) / 8;
            if (code == ch) break;
            ptr += nbytes;
        end

        // Oversize glyphs and bitmaps running off the store are misses.
        if (w > LIM_W || h > LIM_H || ptr + nbytes > STORE_BYTES) begin
            glyph_rows.push_back(MISS_ROW);
            return !hit_unloaded;
        end

        adv       = (w > xadv) ? w : xadv;
        r.found   = 1'b1;
        // Offset bytes of 0x80 and up count as negative, one step short of two's complement.
        r.row_x   = 16'(ox + xb - ((xb < XOFF_NEG) ? 0 : 255));
        r.width   = w[5:0];
        r.advance = adv[7:0];
        r.color   = pen_color_now;

        // An empty glyph still reports one row at the glyph origin.
        if (w == 0 || h == 0) begin
            r.row_y = 16'(oy + yoff);
            r.mask  = '0;
            r.last  = 1'b1;
            glyph_rows.push_back(r);
            return !hit_unloaded;
        end

        // The bitmap is one MSB-first bit stream across all rows.
        cursor = 0;
        for (row = 0; row < h; row++) begin
            mask = '0;
            for (col = 0; col < w; col++) begin
                bytev = font_peek(ptr + cursor / 8);
                mask[col] = bytev[7 - (cursor % 8)];
                cursor++;
            end
            r.row_y = 16'(oy + row + yoff);
            r.mask  = mask;
            r.last  = (row + 1 == h);
            glyph_rows.push_back(r);
        end
        return !hit_unloaded;
    endfunction

    function automatic font_cmd_t random_beat();
        font_cmd_t b;
        b.cmd  = ($urandom_range(0, 1) != 0) ? CMD_DRAW : CMD_LOAD;
        b.addr = 13'($urandom_range(0, STORE_BYTES - 1));
        b.data = 8'($urandom_range(0, 255));
        b.ch   = 8'($urandom_range(0, 255));
        b.ox   = 16'($urandom_range(0, 65535));
        b.oy   = 16'($urandom_range(0, 65535));
        return b;
    endfunction

    function automatic dir_row_t ld(input logic [12:0] addr, input logic [7:0] data);
        dir_row_t d;
        d.beat      = '0;
        d.beat.cmd  = CMD_LOAD;
        d.beat.addr = addr;
        d.beat.data = data;
        d.typed     = 1'b0;
        d.want      = MISS_ROW;
        return d;
    endfunction

    function automatic dir_row_t dr(input logic [7:0] ch, input logic [15:0] ox,
                                    input logic [15:0] oy, input glyph_row_t want);
        dir_row_t d;
        d.beat      = '0;
        d.beat.cmd  = CMD_DRAW;
        d.beat.ch   = ch;
        d.beat.ox   = ox;
        d.beat.oy   = oy;
        d.typed     = 1'b1;
        d.want      = want;
        return d;
    endfunction

    // Drive one input beat, wait for its handshake and record what it should cause.
    task automatic send_item(input font_cmd_t b, input logic typed, input glyph_row_t want);
        // Each idle cycle before the beat is drawn at the sender's idle rate.
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, b.oy, b.ox, b.ch, b.data, b.addr};
        s_axis_tuser  <= b.cmd;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (b.cmd == CMD_LOAD) begin
            font_image[b.addr]   = b.data;
            image_loaded[b.addr] = 1'b1;
        end else if (typed) begin
            rows_due.push_back(want);
        end else begin
            void'(render_glyph(b.ch, b.ox, b.oy));
            foreach (glyph_rows[i]) rows_due.push_back(glyph_rows[i]);
        end
        @(negedge i_clk);
    endtask

    task automatic load_byte(input int unsigned addr, input int unsigned data);
        font_cmd_t b;
        b      = random_beat();
        b.cmd  = CMD_LOAD;
        b.addr = addr[12:0];
        b.data = data[7:0];
        send_item(b, 1'b0, MISS_ROW);
    endtask

    // Stop sending until every expected row has come, then let the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    task automatic set_pen(input logic [15:0] color);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= color;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        pen_color_now = color;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Lay out and load a fresh font from byte 4. The first glyph is of the given kind:
    // a full 32-pixel row, a 32-row glyph, an oversize glyph or an empty glyph.
    task automatic build_font(input int kind);
        int unsigned ptr, n, g, w, h, nb, k, sel;
        logic [7:0]  code;
        bit          fits;
        ptr = FIRST_RECORD;
        font_codes.delete();
        bitmap_addrs.delete();
        n = $urandom_range(2, 4);
        for (g = 0; g < n; g++) begin
            code = 8'($urandom_range(0, 254));
            sel  = (g == 0) ? kind : $urandom_range(0, 9);
            case (sel)
                0: begin
                    w = 32;
                    h = $urandom_range(1, 3);
                end
                1: begin
                    w = $urandom_range(1, 3);
                    h = 32;
                end
                2: begin
                    if ($urandom_range(0, 1) != 0) begin
                        w = $urandom_range(LIM_W + 1, 40);
                        h = $urandom_range(1, 2);
                    end else begin
                        w = $urandom_range(1, 2);
                        h = $urandom_range(LIM_H + 1, 40);
                    end
                end
                3: begin
                    w = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
                    h = (w == 0) ? $urandom_range(0, 8) : 0;
                end
                default: begin
                    w = $urandom_range(1, 10);
                    h = $urandom_range(1, 6);
                end
            endcase
            fits = (w <= LIM_W && h <= LIM_H);
            nb   = (w * h + 7) / 8;
            load_byte(ptr, code);
            load_byte(ptr + 1, $urandom_range(0, 255));
            load_byte(ptr + 2, w);
            load_byte(ptr + 3, h);
            load_byte(ptr + 4, $urandom_range(0, 255));
            load_byte(ptr + 5, $urandom_range(0, 255));
            // Bitmaps of oversize glyphs are never read, so they are not loaded.
            if (fits) begin
                for (k = 0; k < nb; k++) begin
                    bitmap_addrs.push_back(ptr + HDR_BYTES + k);
                    load_byte(ptr + HDR_BYTES + k, $urandom_range(0, 255));
                end
            end
            font_codes.push_back(code);
            ptr += HDR_BYTES + nb;
        end
        load_byte(ptr, END_CODE);
        for (k = 1; k < HDR_BYTES; k++) load_byte(ptr + k, $urandom_range(0, 255));
        font_end = ptr + HDR_BYTES;
    endtask

    // Random draws and loads against the current font. Bitmap rewrites keep the
    // record layout, noise loads only hit bytes no draw reads.
    task automatic mixed_traffic();
        int         k, pick;
        font_cmd_t  b;
        for (k = 0; k < MIXED_ITEMS; k++) begin
            if (k == MIXED_ITEMS / 2) wait_drained();
            pick = $urandom_range(0, 99);
            b    = random_beat();
            if (pick < 75) begin
                b.cmd = CMD_DRAW;
                if (pick < 60) b.ch = font_codes[$urandom_range(0, font_codes.size() - 1)];
                if (render_glyph(b.ch, b.ox, b.oy)) send_item(b, 1'b0, MISS_ROW);
            end else if (pick < 90 && bitmap_addrs.size() != 0) begin
                load_byte(bitmap_addrs[$urandom_range(0, bitmap_addrs.size() - 1)],
                          $urandom_range(0, 255));
            end else if ($urandom_range(0, 1) != 0) begin
                load_byte($urandom_range(0, FIRST_RECORD - 1), $urandom_range(0, 255));
            end else begin
                load_byte($urandom_range(font_end, STORE_BYTES - 1), $urandom_range(0, 255));
            end
        end
    endtask

    // Compare one received row beat with its expectation, field by field.
    task automatic check_row(input glyph_row_t want, input glyph_row_t got);
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
        end
        if (got.row_x !== want.row_x) begin
            $error("row_x: expected 0x%04h, got 0x%04h", want.row_x, got.row_x);
            fail_count++;
        end
        if (got.row_y !== want.row_y) begin
            $error("row_y: expected 0x%04h, got 0x%04h", want.row_y, got.row_y);
            fail_count++;
        end
        if (got.mask !== want.mask) begin
            $error("row_mask: expected 0x%08h, got 0x%08h", want.mask, got.mask);
            fail_count++;
        end
        if (got.width !== want.width) begin
            $error("glyph_width: expected %0d, got %0d", want.width, got.width);
            fail_count++;
        end
        if (got.advance !== want.advance) begin
            $error("advance: expected %0d, got %0d", want.advance, got.advance);
            fail_count++;
        end
        if (got.color !== want.color) begin
            $error("color: expected 0x%04h, got 0x%04h", want.color, got.color);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    // Output monitor: every accepted row beat is matched with the oldest expectation.
    always @(posedge i_clk) begin
        glyph_row_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[63:32], m_axis_tdata[69:64], m_axis_tdata[77:70],
                   m_axis_tdata[93:78], m_axis_tlast};
            if (rows_due.size() == 0) begin
                $error("row beat with no expectation waiting");
                fail_count++;
            end else begin
                check_row(rows_due.pop_front(), got);
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog on cycles in which no channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Directed plan: a one-glyph font with an empty glyph, then the same record
    // grown to 255x255 so that the scan jumps to the end of the store.
    initial begin
        dir_plan[0]  = ld(13'd4, 8'h41);
        dir_plan[1]  = ld(13'd5, 8'hFF);
        dir_plan[2]  = ld(13'd6, 8'h00);
        dir_plan[3]  = ld(13'd7, 8'h05);
        dir_plan[4]  = ld(13'd8, XOFF_NEG);
        dir_plan[5]  = ld(13'd9, 8'h07);
        dir_plan[6]  = ld(13'd10, END_CODE);
        dir_plan[7]  = ld(13'd11, 8'h00);
        dir_plan[8]  = ld(13'd12, 8'hFF);
        dir_plan[9]  = ld(13'd13, 8'h00);
        dir_plan[10] = ld(13'd14, 8'hFF);
        dir_plan[11] = ld(13'd15, 8'h00);
        // Empty glyph at the top corner: both coordinates wrap.
        dir_plan[12] = dr(8'h41, 16'hFFFF, 16'hFFFF,
                          {1'b1, 16'hFF80, 16'h00FE, 32'h0, 6'd0, 8'd7, 16'hFFFF, 1'b1});
        // The terminator code can never be drawn.
        dir_plan[13] = dr(END_CODE, 16'h1234, 16'h5678, MISS_ROW);
        dir_plan[14] = dr(8'h00, 16'h0000, 16'h0000, MISS_ROW);
        dir_plan[15] = ld(13'd6, 8'hFF);
        dir_plan[16] = ld(13'd7, 8'hFF);
        // Oversize glyph.
        dir_plan[17] = dr(8'h41, 16'h0100, 16'h0200, MISS_ROW);
        dir_plan[18] = ld(13'd8139, 8'h42);
        dir_plan[19] = ld(13'd8140, 8'h00);
        dir_plan[20] = ld(13'd8141, 8'd32);
        dir_plan[21] = ld(13'd8142, 8'd32);
        dir_plan[22] = ld(13'd8143, 8'h00);
        dir_plan[23] = ld(13'd8144, 8'h00);
        // Bitmap running off the end of the store.
        dir_plan[24] = dr(8'h42, 16'h0010, 16'h0020, MISS_ROW);
        // Next header past the end of the store.
        dir_plan[25] = dr(8'h43, 16'hFFFF, 16'h0000, MISS_ROW);
    end

    // Main sequence.
    initial begin
        int i, ph;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_plan[i].beat, dir_plan[i].typed, dir_plan[i].want);
        end

        // Random phases: no idling, sender gaps, receiver stalls, then both.
        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            tx_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 34 : 0;
            rx_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 34 : 0;
            case (ph)
                0:       set_pen(16'h0000);
                2:       set_pen(16'hFFFF);
                default: set_pen(16'($urandom_range(0, 65535)));
            endcase
            build_font(ph);
            mixed_traffic();
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/bfge_pkg.sv
rtl/bfge_store.sv
rtl/bitmap_font_glyph_expander.sv
rtl/bfge_checker.sv
tb/tb_top.sv
